@@ rtl/assert_macros.svh @@
// assertion helpers, clocked on clk and held off during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/bsm_pkg.sv @@
`default_nettype none
package bsm_pkg;

  localparam int IN_W          = 32;
  localparam int PROD_W        = 64;
  localparam int WIDTH_DEFAULT = 32;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_ADD,
    OP_SUB
  } booth_op_t;

  // radix-2 booth recoding of the current and previous multiplier bits
  function automatic booth_op_t booth_decode(input logic q0, input logic qp);
    booth_op_t op;
    unique case ({q0, qp})
      2'b10:   op = OP_SUB;
      2'b01:   op = OP_ADD;
      default: op = OP_NONE;
    endcase
    return op;
  endfunction

endpackage
`default_nettype wire

@@ rtl/bsm_in_if.sv @@
`default_nettype none
interface bsm_in_if;
  logic                             valid;
  logic                             ready;
  logic signed [bsm_pkg::IN_W-1:0]  multiplicand;
  logic signed [bsm_pkg::IN_W-1:0]  multiplier;

  modport source (output valid, output multiplicand, output multiplier, input ready);
  modport sink   (input valid, input multiplicand, input multiplier, output ready);
endinterface
`default_nettype wire

@@ rtl/bsm_out_if.sv @@
`default_nettype none
interface bsm_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [bsm_pkg::PROD_W-1:0] product;

  modport source (output valid, output product, input ready);
  modport sink   (input valid, input product, output ready);
endinterface
`default_nettype wire

@@ rtl/bsm_step.sv @@
`default_nettype none
module bsm_step #(
  parameter int WIDTH = bsm_pkg::WIDTH_DEFAULT
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             up_valid,
  output      logic             up_ready,
  input  wire logic [WIDTH:0]   up_acc,
  input  wire logic [WIDTH-1:0] up_q,
  input  wire logic             up_qp,
  input  wire logic [WIDTH-1:0] up_m,
  input  wire logic             dn_ready,
  output      logic             dn_valid,
  output      logic [WIDTH:0]   dn_acc,
  output      logic [WIDTH-1:0] dn_q,
  output      logic             dn_qp,
  output      logic [WIDTH-1:0] dn_m
);

  logic                 valid_r, valid_nxt;
  logic [WIDTH:0]       acc_r, acc_nxt;
  logic [WIDTH-1:0]     q_r, q_nxt;
  logic                 qp_r, qp_nxt;
  logic [WIDTH-1:0]     m_r;
  logic [WIDTH:0]       m_ext;
  logic [WIDTH:0]       sum;
  bsm_pkg::booth_op_t   op;

  assign up_ready = !valid_r || dn_ready;

  always_comb begin
    m_ext = {up_m[WIDTH-1], up_m};
    op    = bsm_pkg::booth_decode(up_q[0], up_qp);
    case (op)
      bsm_pkg::OP_ADD: sum = up_acc + m_ext;
      bsm_pkg::OP_SUB: sum = up_acc - m_ext;
      default:         sum = up_acc;
    endcase
    // arithmetic shift right of {acc, q, qp}
    acc_nxt   = {sum[WIDTH], sum[WIDTH:1]};
    q_nxt     = {sum[0], up_q[WIDTH-1:1]};
    qp_nxt    = up_q[0];
    valid_nxt = up_ready ? up_valid : valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      acc_r <= acc_nxt;
      q_r   <= q_nxt;
      qp_r  <= qp_nxt;
      m_r   <= up_m;
    end
  end

  assign dn_valid = valid_r;
  assign dn_acc   = acc_r;
  assign dn_q     = q_r;
  assign dn_qp    = qp_r;
  assign dn_m     = m_r;

endmodule
`default_nettype wire

@@ rtl/booth_signed_multiplier.sv @@
// radix-2 booth signed multiplier, one booth step per pipeline stage
// an accepted word moves through the registered stages in order; its product leaves the last stage on out
// throughput: one word per cycle while in_ch.ready is high; a stall only holds stages that are full
// in_ch.ready falls only when every stage holds a word and out is stalled
// reset (rst_n, synchronous) clears the stage valid bits; data registers are not reset
`default_nettype none
`include "assert_macros.svh"
module booth_signed_multiplier #(
  parameter int WIDTH = bsm_pkg::WIDTH_DEFAULT
) (
  input wire logic clk,
  input wire logic rst_n,
  bsm_in_if.sink   in_ch,
  bsm_out_if.source out_ch
);

  logic [WIDTH:0]       v;
  logic [WIDTH:0]       rdy;
  logic [WIDTH:0]       acc_s [WIDTH+1];
  logic [WIDTH-1:0]     q_s   [WIDTH+1];
  logic                 qp_s  [WIDTH+1];
  logic [WIDTH-1:0]     m_s   [WIDTH+1];
  logic signed [2*WIDTH:0] prod_full;

  // stage 0 input: empty accumulator, fresh operands
  assign v[0]     = in_ch.valid;
  assign acc_s[0] = '0;
  assign q_s[0]   = in_ch.multiplier[WIDTH-1:0];
  assign qp_s[0]  = 1'b0;
  assign m_s[0]   = in_ch.multiplicand[WIDTH-1:0];
  assign in_ch.ready = rdy[0];

  for (genvar i = 0; i < WIDTH; i++) begin : g_step
    bsm_step #(.WIDTH(WIDTH)) u_step (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (v[i]),
      .up_ready (rdy[i]),
      .up_acc   (acc_s[i]),
      .up_q     (q_s[i]),
      .up_qp    (qp_s[i]),
      .up_m     (m_s[i]),
      .dn_ready (rdy[i+1]),
      .dn_valid (v[i+1]),
      .dn_acc   (acc_s[i+1]),
      .dn_q     (q_s[i+1]),
      .dn_qp    (qp_s[i+1]),
      .dn_m     (m_s[i+1])
    );
  end

  assign rdy[WIDTH] = out_ch.ready;

  // final {acc, q} carries the guard bit; resized (sign-extended or truncated) to the port width
  assign prod_full      = {acc_s[WIDTH], q_s[WIDTH]};
  assign out_ch.valid   = v[WIDTH];
  assign out_ch.product = bsm_pkg::PROD_W'(prod_full);

  `ASSERT_NXT(a_accept_fills_first, in_ch.valid && in_ch.ready, v[1],
    "accepted word did not reach the first stage")
  `ASSERT_IMP(a_backpressure_full, !in_ch.ready, (&v[WIDTH:1]) && !out_ch.ready,
    "input stalled while the pipeline has a free stage")
  `ASSERT_NXT(a_last_held, out_ch.valid && !out_ch.ready, v[WIDTH],
    "last stage dropped a word under backpressure")

endmodule
`default_nettype wire
